// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/ida_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed deque package
// Sizes, command and status codes, item types and address helper.
// ----------------------------------------------------------------------------
package ida_pkg;

  localparam int DEPTH = 64;
  localparam int WIDTH = 32;

  // address, count and index widths
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IXW  = 6;
  localparam int CMPW = (CW > IXW) ? CW : IXW;

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_SHIFT   = 3'd2,
    CMD_UNSHIFT = 3'd3,
    CMD_READ    = 3'd4,
    CMD_WRITE   = 3'd5,
    CMD_REMOVE  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MVRD,
    S_MVWR
  } state_t;

  typedef struct packed {
    logic [2:0]     cmd;
    logic [IXW-1:0] index;
    logic [31:0]    value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [1:0]  status;
    logic [6:0]  count;
  } out_item_t;

  // store port controls
  typedef struct packed {
    logic             re;
    logic [AW-1:0]    raddr;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;
    logic             wval;
    logic             clr;
    logic [AW-1:0]    caddr;
  } store_req_t;

  typedef struct packed {
    logic [WIDTH-1:0] data;
    logic             valid;
  } store_rsp_t;

  // logical position to physical slot of the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

// ===== rtl/core/indexed_deque_array_core.sv =====
// ----------------------------------------------------------------------------
// Indexed deque core
// Ordered list of up to DEPTH words with push, pop, shift, unshift, indexed
// read, write and remove, kept as a ring in one memory.
// ----------------------------------------------------------------------------
// Path: item into cur, EXEC, result into res, then rsp with rsp_valid. Remove
// moves one element per MVRD and MVWR (read then write on the store's single
// read and write ports). Items are taken only in IDLE, and a new item is
// accepted while the previous result waits in the output stage.
// Reset: count, head and all slot valid bits clear together; no sweep.
`include "assert_macros.svh"

module indexed_deque_array_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ida_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ida_pkg::out_item_t rsp
);
  import ida_pkg::*;

  state_t     state, state_next;
  in_item_t   cur;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] k, k_next;
  out_item_t  res, res_next;
  logic       res_full;
  logic       finish;
  store_req_t sreq;
  store_rsp_t srsp;

  logic accept, drain;
  logic [CMPW-1:0] idx_big, cnt_big;
  logic idx_ge_cnt, idx_ge_depth, idx_is_last, mv_last;
  logic [31:0] rd_word;
  logic [WIDTH-1:0] cur_word;

  ida_store u_store (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  // handshake
  assign drain     = res_full && (!rsp_valid || !rsp_stall);
  assign req_stall = !((state == S_IDLE) && (!res_full || drain));
  assign accept    = req_valid && !req_stall;

  // decode of the latched item
  assign idx_big      = CMPW'(cur.index);
  assign cnt_big      = CMPW'(count);
  assign idx_ge_cnt   = idx_big >= cnt_big;
  assign idx_ge_depth = idx_big >= CMPW'(DEPTH);
  assign idx_is_last  = CMPW'(idx_big + CMPW'(1)) == cnt_big;
  assign mv_last      = (CW'(k) + CW'(1)) == (count - CW'(1));
  assign rd_word      = srsp.valid ? 32'(srsp.data) : 32'd0;
  assign cur_word     = WIDTH'(cur.value);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_t'(cur.cmd) == CMD_REMOVE && !idx_ge_cnt && !idx_is_last) begin
          state_next = S_MVRD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MVRD: state_next = S_MVWR;
      S_MVWR: begin
        state_next = mv_last ? S_IDLE : S_MVRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // store controls, counters and result
  always_comb begin
    sreq       = '0;
    count_next = count;
    head_next  = head;
    k_next     = k;
    finish     = 1'b0;
    res_next   = res;

    // reads are issued at accept or in the move loop, writes only in
    // EXEC and MVWR, so a read and a write never share a cycle
    if (accept) begin
      sreq.re = 1'b1;
      case (cmd_t'(req.cmd))
        CMD_POP:   sreq.raddr = phys(head, AW'(count - CW'(1)));
        CMD_SHIFT: sreq.raddr = head;
        default:   sreq.raddr = phys(head, AW'(req.index));
      endcase
    end

    unique case (state)
      S_IDLE: ;
      S_EXEC: begin
        finish             = 1'b1;
        res_next.value_out = 32'd0;
        res_next.status    = ST_OK;
        case (cmd_t'(cur.cmd))
          CMD_PUSH: begin
            if (count == CW'(DEPTH)) begin
              res_next.status = ST_FULL;
            end else begin
              sreq.we    = 1'b1;
              sreq.waddr = phys(head, AW'(count));
              sreq.wdata = cur_word;
              sreq.wval  = 1'b1;
              count_next = count + CW'(1);
            end
          end
          CMD_POP: begin
            if (count == '0) begin
              res_next.status = ST_EMPTY;
            end else begin
              res_next.value_out = rd_word;
              sreq.clr   = 1'b1;
              sreq.caddr = phys(head, AW'(count - CW'(1)));
              count_next = count - CW'(1);
            end
          end
          CMD_SHIFT: begin
            if (count == '0) begin
              res_next.status = ST_EMPTY;
            end else begin
              res_next.value_out = rd_word;
              sreq.clr   = 1'b1;
              sreq.caddr = head;
              head_next  = phys(head, AW'(1));
              count_next = count - CW'(1);
            end
          end
          CMD_UNSHIFT: begin
            if (count == CW'(DEPTH)) begin
              res_next.status = ST_FULL;
            end else begin
              head_next  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
              sreq.we    = 1'b1;
              sreq.waddr = head_next;
              sreq.wdata = cur_word;
              sreq.wval  = 1'b1;
              count_next = count + CW'(1);
            end
          end
          CMD_READ: begin
            if (idx_ge_cnt) res_next.status = ST_RANGE;
            else            res_next.value_out = rd_word;
          end
          CMD_WRITE: begin
            if (idx_ge_depth) begin
              res_next.status = ST_RANGE;
            end else begin
              // gap slots past the old end are already not valid: read zero
              sreq.we    = 1'b1;
              sreq.waddr = phys(head, AW'(cur.index));
              sreq.wdata = cur_word;
              sreq.wval  = 1'b1;
              if (idx_ge_cnt) count_next = CW'(cur.index) + CW'(1);
            end
          end
          CMD_REMOVE: begin
            if (idx_ge_cnt) begin
              res_next.status = ST_RANGE;
            end else if (idx_is_last) begin
              sreq.clr   = 1'b1;
              sreq.caddr = phys(head, AW'(cur.index));
              count_next = count - CW'(1);
            end else begin
              finish = 1'b0;
              k_next = AW'(cur.index);
            end
          end
          default: ;
        endcase
        res_next.count = 7'(count_next);
      end
      S_MVRD: begin
        sreq.re    = 1'b1;
        sreq.raddr = phys(head, AW'(k + AW'(1)));
      end
      S_MVWR: begin
        // move slot k+1 into slot k, valid bit travels with it
        sreq.we    = 1'b1;
        sreq.waddr = phys(head, k);
        sreq.wdata = srsp.data;
        sreq.wval  = srsp.valid;
        k_next     = k + AW'(1);
        if (mv_last) begin
          sreq.clr           = 1'b1;
          sreq.caddr         = phys(head, AW'(k + AW'(1)));
          count_next         = count - CW'(1);
          finish             = 1'b1;
          res_next.value_out = 32'd0;
          res_next.status    = ST_OK;
          res_next.count     = 7'(count_next);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      res_full  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      if (finish)     res_full <= 1'b1;
      else if (drain) res_full <= 1'b0;
      if (drain)                        rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) cur <= req;
    k <= k_next;
    if (finish) res <= res_next;
    if (drain)  rsp <= res;
  end

  // checks
  `ASSERT_SAME(a_count_cap, 1'b1, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC)
  `ASSERT_NEXT(a_idle_count, state == S_IDLE, $stable(count) && $stable(head))
  `ASSERT_SAME(a_move_bound, state == S_MVRD, (CW'(k) + CW'(1)) < count)

endmodule

// ===== rtl/core/ida_store.sv =====
// ----------------------------------------------------------------------------
// Indexed deque element store
// Ring memory with one write and one read port, registered read data, and a
// slot valid bit per entry that is read out beside the data as rsp.valid.
// ----------------------------------------------------------------------------
module ida_store (
  input  logic               clk,
  input  logic               rst,
  input  ida_pkg::store_req_t req,
  output ida_pkg::store_rsp_t rsp
);
  import ida_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid, valid_next;
  logic [WIDTH-1:0] rd_data;
  logic             rd_valid;

  assign rsp = {rd_data, rd_valid};

  // data array: write port and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

  // valid bit updates: a write wins over a clear of the same slot
  always_comb begin
    valid_next = valid;
    if (req.clr) valid_next[req.caddr] = 1'b0;
    if (req.we)  valid_next[req.waddr] = req.wval;
  end

  // valid bits, all cleared together at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      valid <= valid_next;
      if (req.re) rd_valid <= valid[req.raddr];
    end
  end

endmodule

// ===== tb/indexed_deque_array_core_test.sv =====
// ----------------------------------------------------------------------------
// Indexed deque core testbench
// Sends command items through the request channel and keeps a software copy
// of the list. It checks every reply field by field against that copy, with
// random sender gaps, random receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module indexed_deque_array_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ida_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;  // undefined code, changes nothing and gets an OK reply
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 300;         // covers the longest remove

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  in_item_t  req;
  logic      rsp_valid;
  logic      rsp_stall;
  out_item_t rsp;

  indexed_deque_array_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // shadow of the list
  logic [31:0] mirror_words [DEPTH];
  int unsigned mirror_count;
  bit          growing;

  out_item_t   pending_replies [$];
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int          hold_len;
  int unsigned err_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned status_seen [4];
  int unsigned cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[indexed_deque_array_core] ERROR");
      $finish;
    end
  end

  // receiver stall: random, or held high while hold_len runs down
  always @(negedge clk) begin
    if (hold_len > 0) begin
      rsp_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // apply one command to the shadow list and return the reply it should give
  function automatic out_item_t deque_apply(input in_item_t it);
    out_item_t   r;
    status_t     st;
    logic [31:0] vout;
    int unsigned k;
    int unsigned ix;
    st   = ST_OK;
    vout = '0;
    ix   = it.index;
    case (it.cmd)
      CMD_PUSH: begin
        if (mirror_count >= DEPTH) st = ST_FULL;
        else begin
          mirror_words[mirror_count] = it.value;
          mirror_count++;
        end
      end
      CMD_POP: begin
        if (mirror_count == 0) st = ST_EMPTY;
        else begin
          vout = mirror_words[mirror_count-1];
          mirror_words[mirror_count-1] = '0;
          mirror_count--;
        end
      end
      CMD_SHIFT, CMD_REMOVE: begin
        if (it.cmd == CMD_SHIFT) ix = 0;
        if (it.cmd == CMD_SHIFT && mirror_count == 0) st = ST_EMPTY;
        else if (ix >= mirror_count) st = ST_RANGE;
        else begin
          if (it.cmd == CMD_SHIFT) vout = mirror_words[0];
          // later elements move one place forward
          for (k = ix; k + 1 < mirror_count; k++) mirror_words[k] = mirror_words[k+1];
          mirror_words[mirror_count-1] = '0;
          mirror_count--;
        end
      end
      CMD_UNSHIFT: begin
        if (mirror_count >= DEPTH) st = ST_FULL;
        else begin
          for (k = mirror_count; k > 0; k--) mirror_words[k] = mirror_words[k-1];
          mirror_words[0] = it.value;
          mirror_count++;
        end
      end
      CMD_READ: begin
        if (ix >= mirror_count) st = ST_RANGE;
        else vout = mirror_words[ix];
      end
      CMD_WRITE: begin
        if (ix >= DEPTH) st = ST_RANGE;
        else begin
          // write past the end zero-fills the gap
          if (ix >= mirror_count) begin
            for (k = mirror_count; k < ix; k++) mirror_words[k] = '0;
            mirror_count = ix + 1;
          end
          mirror_words[ix] = it.value;
        end
      end
      default: ;
    endcase
    status_seen[st]++;
    r.value_out = vout;
    r.status    = st;
    r.count     = 7'(mirror_count);
    return r;
  endfunction

  function automatic in_item_t mk(input logic [2:0] c, input int unsigned ix,
                                  input logic [31:0] v);
    in_item_t it;
    it.cmd   = c;
    it.index = IXW'(ix);
    it.value = v;
    return it;
  endfunction

  // random command, biased to grow the list to full and then drain it
  function automatic in_item_t pick_command();
    int unsigned roll;
    int unsigned ix;
    logic [2:0]  c;
    if (mirror_count >= DEPTH) growing = 1'b0;
    else if (mirror_count == 0) growing = 1'b1;
    else if ($urandom_range(49) == 0) growing = ~growing;
    roll = $urandom_range(99);
    if (growing) begin
      if (roll < 35) c = CMD_PUSH;
      else if (roll < 55) c = CMD_UNSHIFT;
      else if (roll < 62) c = CMD_WRITE;
      else if (roll < 80) c = CMD_READ;
      else if (roll < 87) c = CMD_POP;
      else if (roll < 93) c = CMD_SHIFT;
      else if (roll < 99) c = CMD_REMOVE;
      else c = CMD_UNUSED;
    end else begin
      if (roll < 10) c = CMD_PUSH;
      else if (roll < 15) c = CMD_UNSHIFT;
      else if (roll < 18) c = CMD_WRITE;
      else if (roll < 35) c = CMD_READ;
      else if (roll < 55) c = CMD_POP;
      else if (roll < 72) c = CMD_SHIFT;
      else if (roll < 99) c = CMD_REMOVE;
      else c = CMD_UNUSED;
    end
    // mostly a valid position, sometimes anywhere
    if (mirror_count > 0 && $urandom_range(3) != 0) ix = $urandom_range(mirror_count - 1);
    else ix = $urandom_range(63);
    return mk(c, ix, $urandom());
  endfunction

  // offer one item, with random gaps first, and predict its reply on accept
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (req_stall);
    pending_replies.push_back(deque_apply(it));
    sent_count++;
  endtask

  // stop offering and wait until every reply is back
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // reply checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_replies.size() == 0) begin
        $error("reply with nothing outstanding: value_out %h status %0d count %0d",
               rsp.value_out, rsp.status, rsp.count);
        err_count++;
      end else begin
        want = pending_replies.pop_front();
        checked_count++;
        if (rsp.value_out !== want.value_out) begin
          $error("value_out: expected %h, actual %h", want.value_out, rsp.value_out);
          err_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          err_count++;
        end
        if (rsp.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, rsp.count);
          err_count++;
        end
      end
    end
  end

  // error paths on an empty list, extremes of index and value, full list
  task automatic test_directed();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_item(mk(CMD_POP, 0, '0));
    send_item(mk(CMD_SHIFT, 0, '0));
    send_item(mk(CMD_READ, 0, '0));
    send_item(mk(CMD_REMOVE, 63, '0));
    send_item(mk(CMD_UNUSED, 63, '1));
    send_item(mk(CMD_PUSH, 0, 32'hFFFF_FFFF));
    send_item(mk(CMD_PUSH, 63, 32'h0000_0000));
    send_item(mk(CMD_UNSHIFT, 0, 32'hA5A5_5A5A));
    send_item(mk(CMD_READ, 0, '0));
    send_item(mk(CMD_READ, 2, '0));
    send_item(mk(CMD_READ, 3, '0));
    send_item(mk(CMD_WRITE, 63, 32'h8000_0001));  // extends to a full list
    send_item(mk(CMD_READ, 10, '0));
    send_item(mk(CMD_PUSH, 0, 32'h1234_5678));
    send_item(mk(CMD_UNSHIFT, 0, 32'h1234_5678));
    send_item(mk(CMD_READ, 63, '0));
    send_item(mk(CMD_REMOVE, 0, '0));               // longest move
    send_item(mk(CMD_REMOVE, 62, '0));              // last element
    send_item(mk(CMD_WRITE, 5, 32'h5555_AAAA));
    send_item(mk(CMD_REMOVE, 20, '0));
    send_item(mk(CMD_POP, 0, '0));
    send_item(mk(CMD_SHIFT, 0, '0));
    send_item(mk(CMD_UNUSED, 0, '0));
    wait_drained();
  endtask

  // random commands under one idling pattern
  task automatic test_random_mix(input int unsigned snd_pct, input int unsigned rcv_pct,
                                 input int unsigned n);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (n) send_item(pick_command());
    wait_drained();
  endtask

  // long output hold-off while the sender keeps offering, so the input stalls
  task automatic test_output_hold();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    @(posedge clk);
    hold_len = 300;
    repeat (80) send_item(pick_command());
    wait_drained();
  endtask

  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    rsp_stall    = 1'b0;
    hold_len     = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    mirror_count = 0;
    growing      = 1'b1;
    foreach (mirror_words[i]) mirror_words[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(11, 69, 380);
    test_random_mix(69, 11, 380);
    test_output_hold();
    test_random_mix(0, 0, 300);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands, checked %0d replies over directed, random and hold-off runs.",
             sent_count, checked_count);
    $display("Reply status tally: ok %0d, empty %0d, full %0d, out of range %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_RANGE]);
    if (err_count == 0 && pending_replies.size() == 0)
      $display("[indexed_deque_array_core] OK");
    else
      $display("[indexed_deque_array_core] ERROR");
    $finish;
  end

endmodule
